// File: rtl/lkjc_pkg.sv
// Shared constants, key band table, types and control structs for the keypad jog controller.
`default_nettype none

package lkjc_pkg;

    localparam int AdcW    = 10;
    localparam int SpdW    = 16;
    localparam int ThrW    = 8;
    localparam int CfgIdxW = 3;
    localparam int DivNW   = 22;
    localparam int DivDW   = 16;
    localparam int DivCntW = 5;
    localparam int NumBand = 10;
    localparam int NumCh   = 3;

    localparam logic [DivCntW-1:0] DivCntLast = DivCntW'(DivNW - 1);

    // divide by three as (n * ceil(2^18 / 3)) >> 18, exact for n below 2^17
    localparam int                  ThirdShift = 18;
    localparam int                  ThirdProdW = 34;
    localparam logic [SpdW:0]       ThirdRecip = 17'd87382;

    // key kinds
    localparam logic [1:0] KEY_NONE   = 2'd0;
    localparam logic [1:0] KEY_SWITCH = 2'd1;
    localparam logic [1:0] KEY_FWD    = 2'd2;
    localparam logic [1:0] KEY_BWD    = 2'd3;

    // speed levels
    localparam logic [1:0] LVL_MIN        = 2'd0;
    localparam logic [1:0] LVL_THIRD      = 2'd1;
    localparam logic [1:0] LVL_TWO_THIRDS = 2'd2;
    localparam logic [1:0] LVL_MAX        = 2'd3;

    // commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_M1_MIN = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_M1_MAX = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_M2_MIN = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_M2_MAX = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_THR    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_DUAL   = 3'd5;

    // debounce channels
    localparam int CH_FWD = 0;
    localparam int CH_BWD = 1;
    localparam int CH_SW  = 2;

    typedef struct packed {
        logic [AdcW-1:0] lo;
        logic [AdcW-1:0] hi;
        logic [1:0]      kind;
        logic [1:0]      lvl;
    } t_band;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] lvl;
    } t_key;

    localparam t_band BANDS [NumBand] = '{
        '{10'd900, 10'd990, KEY_NONE,   LVL_MIN},
        '{10'd800, 10'd899, KEY_SWITCH, LVL_MIN},
        '{10'd690, 10'd799, KEY_FWD,    LVL_TWO_THIRDS},
        '{10'd400, 10'd500, KEY_FWD,    LVL_MAX},
        '{10'd111, 10'd210, KEY_BWD,    LVL_TWO_THIRDS},
        '{10'd30,  10'd110, KEY_BWD,    LVL_MAX},
        '{10'd600, 10'd689, KEY_FWD,    LVL_MIN},
        '{10'd330, 10'd399, KEY_FWD,    LVL_THIRD},
        '{10'd501, 10'd600, KEY_BWD,    LVL_MIN},
        '{10'd211, 10'd350, KEY_BWD,    LVL_THIRD}
    };

    // first matching band wins; gaps decode as no key
    function automatic t_key decode_key(input logic [AdcW-1:0] adc);
        t_key k;
        logic hit;
        k.kind = KEY_NONE;
        k.lvl  = LVL_MIN;
        hit    = 1'b0;
        for (int i = 0; i < NumBand; i++) begin
            if (!hit && adc >= BANDS[i].lo && adc <= BANDS[i].hi) begin
                k.kind = BANDS[i].kind;
                k.lvl  = BANDS[i].lvl;
                hit    = 1'b1;
            end
        end
        return k;
    endfunction

    typedef struct packed {
        logic cap;
        logic lvl_start;
        logic lvl_load;
        logic map_start;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_lvl_div;
        logic map_empty;
        logic div_done;
        logic out_free;
    } t_ctrl_stat;

endpackage

`default_nettype wire

// File: rtl/lkjc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module lkjc_div
    import lkjc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DivNW-1:0]  i_dividend,
    input  wire logic [DivDW-1:0]  i_divisor,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [DivNW-1:0]       o_quotient
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DivCntW-1:0] r_cnt, n_cnt;
    logic [DivNW-1:0]   r_quo, n_quo;
    logic [DivDW-1:0]   r_rem, n_rem;
    logic [DivDW-1:0]   r_div, n_div;

    logic [DivDW:0] rem_sh;
    logic [DivDW:0] rem_sub;
    logic           ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DivNW-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        ge      = rem_sh >= {1'b0, r_div};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? rem_sub[DivDW-1:0] : rem_sh[DivDW-1:0];
            n_quo = {r_quo[DivNW-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DivCntLast) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: rtl/lkjc_ctrl.sv
// Sequencer for one keypad word: capture, level division, speed mapping, finish.
`default_nettype none

module lkjc_ctrl
    import lkjc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_ctrl_stat i_stat,
    output t_ctrl_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_LEVEL      = 3'd1;
    localparam logic [2:0] S_LEVEL_WAIT = 3'd2;
    localparam logic [2:0] S_MAP        = 3'd3;
    localparam logic [2:0] S_MAP_WAIT   = 3'd4;
    localparam logic [2:0] S_FINISH     = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_LEVEL;
                end
            end
            S_LEVEL: begin
                if (i_stat.need_lvl_div) begin
                    o_cmd.lvl_start = 1'b1;
                    n_state         = S_LEVEL_WAIT;
                end else begin
                    o_cmd.lvl_load = 1'b1;
                    n_state        = S_MAP;
                end
            end
            S_LEVEL_WAIT: begin
                // third was registered last cycle; load the level
                o_cmd.lvl_load = 1'b1;
                n_state        = S_MAP;
            end
            S_MAP: begin
                if (i_stat.map_empty) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.map_start = 1'b1;
                    n_state         = S_MAP_WAIT;
                end
            end
            S_MAP_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// File: rtl/lkjc_dpath.sv
// Datapath: settings, key decode, speed arithmetic, debounce state and output register.
`default_nettype none

module lkjc_dpath
    import lkjc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [SpdW-1:0]    i_cfg_data,
    input  wire logic [AdcW-1:0]    i_adc_value,
    input  wire logic               i_motor_moving,
    input  wire logic [SpdW-1:0]    i_motor_speed_now,
    input  wire t_ctrl_cmd          i_cmd,
    output t_ctrl_stat              o_stat,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_command,
    output logic [SpdW-1:0]         o_speed_value,
    output logic                    o_toward_forward_end,
    output logic                    o_selected_motor,
    output logic                    o_motor_toggled,
    output logic                    o_forward_led,
    output logic                    o_backward_led,
    output logic                    o_motor_led
);

    // settings
    logic [SpdW-1:0] r_m1_min, r_m1_max, r_m2_min, r_m2_max;
    logic [ThrW-1:0] r_thr;
    logic            r_dual;

    // per-word captured fields
    logic [1:0]      r_kind, r_lvl;
    logic            r_moving;
    logic [SpdW-1:0] r_now;
    logic [SpdW-1:0] r_level, n_level;
    logic            r_map_neg;
    logic [SpdW-1:0] r_lvl_q;

    // persistent state
    logic [NumCh-1:0] r_acc, n_acc;
    logic [ThrW-1:0]  r_cnt [NumCh];
    logic [ThrW-1:0]  n_cnt [NumCh];
    logic [SpdW-1:0]  r_saved, n_saved;
    logic             r_motor, n_motor;

    // output register
    logic            r_out_valid;
    logic [1:0]      r_out_cmd, n_out_cmd;
    logic [SpdW-1:0] r_out_speed, n_out_speed;
    logic            r_out_toward, n_out_toward;
    logic            r_out_motor;
    logic            r_out_toggled, n_out_toggled;
    logic            r_out_fwd, r_out_bwd, r_out_mled;

    t_key key_in;
    logic speed_key;

    // level arithmetic
    logic [SpdW-1:0]       sel_lo, sel_hi;
    logic [SpdW+1:0]       d_s;
    logic                  d_neg;
    logic [SpdW+1:0]       d_abs;
    logic [SpdW:0]         lvl_num;
    logic [ThirdProdW-1:0] lvl_prod;
    logic [SpdW-1:0]       lvl_q;
    logic [SpdW+1:0]       lvl_sum;

    // mapping arithmetic
    logic             map_empty;
    logic [SpdW:0]    diff;
    logic             diff_neg;
    logic [SpdW:0]    diff_abs;
    logic [SpdW-1:0]  diff_mag;
    logic [DivNW-1:0] prod;
    logic [SpdW-1:0]  map_div;
    logic [DivNW:0]   pos_sum;
    logic [SpdW-1:0]  mapped;

    // divider
    logic             div_start, div_busy, div_done;
    logic [DivNW-1:0] div_n, div_q;
    logic [DivDW-1:0] div_d;

    // finish step
    logic [NumCh-1:0] raw, trig;
    logic             fwd, bwd, sw, moving_eff, toggle;

    assign key_in    = decode_key(i_adc_value);
    assign speed_key = (r_kind == KEY_FWD) || (r_kind == KEY_BWD);

    always_comb begin
        sel_lo   = r_motor ? r_m2_min : r_m1_min;
        sel_hi   = r_motor ? r_m2_max : r_m1_max;
        d_s      = {2'b00, sel_hi} - {2'b00, sel_lo};
        d_neg    = d_s[SpdW+1];
        d_abs    = d_neg ? (~d_s + 1'b1) : d_s;
        lvl_num  = (r_lvl == LVL_THIRD) ? {1'b0, d_abs[SpdW-1:0]} : {d_abs[SpdW-1:0], 1'b0};
        lvl_prod = ThirdProdW'(lvl_num) * ThirdProdW'(ThirdRecip);
        lvl_q    = lvl_prod[ThirdShift +: SpdW];
        // level = lo + trunc(d*k/3), sign of d restored on the magnitude quotient
        lvl_sum = d_neg ? ({2'b00, sel_lo} - {2'b00, r_lvl_q})
                        : ({2'b00, sel_lo} + {2'b00, r_lvl_q});
        if (!speed_key) begin
            n_level = '0;
        end else begin
            unique case (r_lvl)
                LVL_MIN:        n_level = sel_lo;
                LVL_MAX:        n_level = sel_hi;
                LVL_THIRD,
                LVL_TWO_THIRDS: n_level = lvl_sum[SpdW-1:0];
                default:        n_level = sel_lo;
            endcase
        end
    end

    always_comb begin
        map_empty = (r_m1_max <= r_m1_min);
        diff      = {1'b0, r_level} - {1'b0, r_m1_min};
        diff_neg  = diff[SpdW];
        diff_abs  = diff_neg ? (~diff + 1'b1) : diff;
        diff_mag  = diff_abs[SpdW-1:0];
        // times 62 as 64 - 2
        prod      = ({6'b0, diff_mag} << 6) - ({6'b0, diff_mag} << 1);
        map_div   = r_m1_max - r_m1_min;
        pos_sum   = {1'b0, div_q} + (DivNW+1)'(2);
        if (map_empty) begin
            mapped = SpdW'(2);
        end else if (r_map_neg) begin
            mapped = (div_q > DivNW'(2)) ? '0 : SpdW'(2) - div_q[SpdW-1:0];
        end else begin
            mapped = (pos_sum > (DivNW+1)'(16'hFFFF)) ? 16'hFFFF : pos_sum[SpdW-1:0];
        end
    end

    assign div_start = i_cmd.map_start;
    assign div_n     = prod;
    assign div_d     = map_div;

    lkjc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        raw[CH_FWD] = (r_kind == KEY_FWD);
        raw[CH_BWD] = (r_kind == KEY_BWD);
        raw[CH_SW]  = (r_kind == KEY_SWITCH);
        for (int c = 0; c < NumCh; c++) begin
            n_acc[c] = r_acc[c];
            n_cnt[c] = r_cnt[c];
            trig[c]  = 1'b0;
            if (raw[c] == r_acc[c]) begin
                n_cnt[c] = '0;
            end else if (r_cnt[c] < r_thr) begin
                n_cnt[c] = r_cnt[c] + 1'b1;
            end else begin
                n_acc[c] = raw[c];
                n_cnt[c] = '0;
                trig[c]  = 1'b1;
            end
        end
        fwd = n_acc[CH_FWD];
        bwd = n_acc[CH_BWD];
        sw  = n_acc[CH_SW];

        n_saved       = r_saved;
        n_out_cmd     = CMD_NONE;
        n_out_speed   = '0;
        n_out_toward  = 1'b0;
        moving_eff    = r_moving;
        toggle        = 1'b0;
        if (fwd || bwd) begin
            if (trig[CH_FWD] || trig[CH_BWD]) begin
                n_saved = r_now;
            end
            n_out_speed = mapped;
            if (!r_moving) begin
                n_out_cmd    = CMD_START;
                n_out_toward = fwd;
            end else begin
                n_out_cmd = CMD_SET;
            end
        end else begin
            // release of a jog key: stop and restore, the motor then counts as stopped
            if (trig[CH_FWD] || trig[CH_BWD]) begin
                n_out_cmd   = CMD_STOP;
                n_out_speed = r_saved;
                moving_eff  = 1'b0;
            end
            toggle = r_dual && sw && trig[CH_SW] && !moving_eff;
        end
        n_motor       = r_motor ^ toggle;
        n_out_toggled = toggle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_min    <= SpdW'(2);
            r_m1_max    <= SpdW'(64);
            r_m2_min    <= SpdW'(2);
            r_m2_max    <= SpdW'(64);
            r_thr       <= ThrW'(5);
            r_dual      <= 1'b0;
            r_acc       <= '0;
            r_cnt       <= '{default: '0};
            r_saved     <= '0;
            r_motor     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_M1_MIN: r_m1_min <= i_cfg_data;
                    REG_M1_MAX: r_m1_max <= i_cfg_data;
                    REG_M2_MIN: r_m2_min <= i_cfg_data;
                    REG_M2_MAX: r_m2_max <= i_cfg_data;
                    REG_THR:    r_thr    <= i_cfg_data[ThrW-1:0];
                    REG_DUAL:   r_dual   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_acc       <= n_acc;
                r_cnt       <= n_cnt;
                r_saved     <= n_saved;
                r_motor     <= n_motor;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind   <= key_in.kind;
            r_lvl    <= key_in.lvl;
            r_moving <= i_motor_moving;
            r_now    <= i_motor_speed_now;
        end
        if (i_cmd.lvl_start) begin
            r_lvl_q <= lvl_q;
        end
        if (i_cmd.lvl_load) begin
            r_level <= n_level;
        end
        if (i_cmd.map_start) begin
            r_map_neg <= diff_neg;
        end
        if (i_cmd.finish) begin
            r_out_cmd     <= n_out_cmd;
            r_out_speed   <= n_out_speed;
            r_out_toward  <= n_out_toward;
            r_out_motor   <= n_motor;
            r_out_toggled <= n_out_toggled;
            r_out_fwd     <= fwd;
            r_out_bwd     <= bwd;
            r_out_mled    <= r_dual && !n_motor;
        end
    end

    assign o_stat.need_lvl_div = speed_key && ((r_lvl == LVL_THIRD) || (r_lvl == LVL_TWO_THIRDS));
    assign o_stat.map_empty    = map_empty;
    assign o_stat.div_done     = div_done;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid          = r_out_valid;
    assign o_command            = r_out_cmd;
    assign o_speed_value        = r_out_speed;
    assign o_toward_forward_end = r_out_toward;
    assign o_selected_motor     = r_out_motor;
    assign o_motor_toggled      = r_out_toggled;
    assign o_forward_led        = r_out_fwd;
    assign o_backward_led       = r_out_bwd;
    assign o_motor_led          = r_out_mled;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_toggle_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && n_out_toggled) |=> (r_motor != $past(r_motor)))
        else $error("toggle reported without motor change");

    a_jog_has_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out_cmd == CMD_SET) || (r_out_cmd == CMD_START)))
            |-> (r_out_fwd || r_out_bwd))
        else $error("jog command without a held jog key");

    a_toward_start_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_toward) |-> (r_out_cmd == CMD_START))
        else $error("start target set on a non-start command");

endmodule

`default_nettype wire

// File: rtl/ladder_keypad_jog_controller_top.sv
// A third or two-thirds level key first passes the level division; every word then
// passes the 22-step speed-mapping division, which an empty mapping range skips.
// Throughput: one word at a time; the next word is taken the cycle after the result
// is loaded, and a result waiting on the output stalls that.
// Reset (synchronous, active low): settings to defaults, debounce state, saved speed
// and motor choice cleared, output empty.
`default_nettype none

module ladder_keypad_jog_controller_top
    import lkjc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [SpdW-1:0]    i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [AdcW-1:0]    i_adc_value,
    input  wire logic               i_motor_moving,
    input  wire logic [SpdW-1:0]    i_motor_speed_now,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_command,
    output logic [SpdW-1:0]         o_speed_value,
    output logic                    o_toward_forward_end,
    output logic                    o_selected_motor,
    output logic                    o_motor_toggled,
    output logic                    o_forward_led,
    output logic                    o_backward_led,
    output logic                    o_motor_led
);

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    lkjc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lkjc_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_adc_value          (i_adc_value),
        .i_motor_moving       (i_motor_moving),
        .i_motor_speed_now    (i_motor_speed_now),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_command            (o_command),
        .o_speed_value        (o_speed_value),
        .o_toward_forward_end (o_toward_forward_end),
        .o_selected_motor     (o_selected_motor),
        .o_motor_toggled      (o_motor_toggled),
        .o_forward_led        (o_forward_led),
        .o_backward_led       (o_backward_led),
        .o_motor_led          (o_motor_led)
    );

endmodule

`default_nettype wire
